FILE: hdl/vpsc_pkg.sv
// ---------------------------------------------------------------------------
// vpsc_pkg
// Shared widths, types and helpers for the Verlet particle step block.
// ---------------------------------------------------------------------------
package vpsc_pkg;

    localparam int POS_W   = 24;            // Q16.8 position width
    localparam int RAD_W   = 23;            // limit radius width
    localparam int DT_W    = 16;            // Q0.16 time step
    localparam int MUL_AW  = 24;            // shared multiplier operand a
    localparam int MUL_BW  = 32;            // shared multiplier operand b
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int SQ_W    = 50;            // radicand width (sum of two squares)
    localparam int ROOT_W  = 25;            // root / divisor width
    localparam int NUM_W   = 48;            // division numerator width
    localparam int QUO_W   = 24;            // quotient width
    localparam int CNT_W   = 5;

    // configuration register indexes
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_LIMIT_R  = 2'd2;

    // iterative unit operation
    typedef enum logic {
        SDU_SQRT = 1'b0,
        SDU_DIV  = 1'b1
    } t_sdu_op;

    typedef struct packed {
        logic    start;
        t_sdu_op op;
    } t_sdu_cmd;

    typedef struct packed {
        logic                done;
        logic [ROOT_W-1:0]   value;
    } t_sdu_res;

    // saturate a 28-bit signed value to the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [27:0] v);
        logic signed [27:0] hi;
        logic signed [27:0] lo;
        hi = 28'sd8388607;
        lo = -28'sd8388608;
        if (v > hi)
            sat_pos = hi[POS_W-1:0];
        else if (v < lo)
            sat_pos = lo[POS_W-1:0];
        else
            sat_pos = v[POS_W-1:0];
    endfunction

endpackage

FILE: hdl/vpsc_mul.sv
// ---------------------------------------------------------------------------
// vpsc_mul
// Shared unsigned multiplier, 24 x 32 bits, product registered.
// ---------------------------------------------------------------------------
module vpsc_mul
    import vpsc_pkg::*;
(
    input  logic              i_clk,
    input  logic [MUL_AW-1:0] i_a,
    input  logic [MUL_BW-1:0] i_b,
    output logic [MUL_PW-1:0] o_prod
);

    logic [MUL_PW-1:0] r_prod;

    // one product per cycle, ready the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: hdl/vpsc_sdu.sv
// ---------------------------------------------------------------------------
// vpsc_sdu
// Iterative square root / divide unit, one result bit per cycle through a
// single shared compare-and-subtract.
// ---------------------------------------------------------------------------
module vpsc_sdu
    import vpsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sdu_cmd          i_cmd,
    input  logic [SQ_W-1:0]   i_radicand,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    output t_sdu_res          o_res
);

    logic              r_busy;
    t_sdu_op           r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [25:0]       r_rem;
    logic [ROOT_W-1:0] r_acc;
    logic [SQ_W-1:0]   r_src;
    logic [ROOT_W-1:0] r_den;
    logic              r_done;

    logic [27:0] cand;
    logic [27:0] trial;
    logic [28:0] diff;
    logic        ge;
    logic [CNT_W-1:0] last;

    // candidate remainder and trial value for the current digit
    always_comb begin
        if (r_op == SDU_SQRT) begin
            cand  = {r_rem, r_src[SQ_W-1 -: 2]};
            trial = {1'b0, r_acc, 2'b01};
            last  = CNT_W'(ROOT_W - 1);
        end else begin
            cand  = {2'b00, r_rem[24:0], r_src[SQ_W-1]};
            trial = {3'b000, r_den};
            last  = CNT_W'(QUO_W - 1);
        end
        diff = {1'b0, cand} - {1'b0, trial};
        ge   = ~diff[28];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= SDU_SQRT;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_den  <= i_den;
                if (i_cmd.op == SDU_SQRT) begin
                    r_rem <= '0;
                    r_src <= i_radicand;
                end else begin
                    r_rem <= 26'(i_num[NUM_W-1 -: QUO_W]);
                    r_src <= {i_num[QUO_W-1:0], 26'd0};
                end
            end else if (r_busy) begin
                r_rem <= ge ? diff[25:0] : cand[25:0];
                r_acc <= {r_acc[ROOT_W-2:0], ge};
                r_src <= (r_op == SDU_SQRT) ? {r_src[SQ_W-3:0], 2'b00}
                                            : {r_src[SQ_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.value = r_acc;

endmodule

FILE: hdl/verlet_particle_step_circle_bound.sv
// ---------------------------------------------------------------------------
// verlet_particle_step_circle_bound
// Position Verlet step for one particle with a circular bound, Q16.8.
//
//  channel  dir  fields (tdata/tuser, low bit first)
//  s_axis   in   tdata: accel_x[23:0] accel_y[47:24] time_step[63:48]; tuser: mode
//  m_axis   out  tdata: pos_x[23:0] pos_y[47:24] was_clamped[48], zero pad
//  cfg      in   i_cfg_idx 0 center_x, 1 center_y, 2 limit_radius
//
// A load beat goes straight to the output state; a clamped step beat runs a root
// and two divides in the shared iterative unit, with all products from one multiplier.
// s_axis_tready is high only in idle. A result waits in the output register;
// the next beat may be taken meanwhile and stalls before its commit.
// Reset is synchronous; positions clear to zero, registers to their defaults.
// ---------------------------------------------------------------------------
module verlet_particle_step_circle_bound
    import vpsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // accel_x, accel_y, time_step
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // pos_x, pos_y, was_clamped
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIFF, ST_MXX, ST_MYY, ST_MRR, ST_CMP, ST_SQRT,
        ST_MX, ST_DXS, ST_DXW, ST_MY, ST_DYS, ST_DYW, ST_PROJ,
        ST_MDT, ST_MAX, ST_MAY, ST_SUM, ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic signed [POS_W-1:0] r_cx, r_cy;
    logic [RAD_W-1:0]        r_rad;

    // particle state
    logic signed [POS_W-1:0] r_cur_x, r_cur_y, r_prev_x, r_prev_y;

    // item and working registers
    logic                    r_load;
    logic signed [POS_W-1:0] r_ax_in, r_ay_in;
    logic [DT_W-1:0]         r_dt;
    logic [POS_W-1:0]        r_mx, r_my;      // |current - center|
    logic                    r_sx, r_sy;
    logic [SQ_W-1:0]         r_d2;
    logic [ROOT_W-1:0]       r_d;
    logic [QUO_W-1:0]        r_ox;
    logic                    r_clamp;
    logic [31:0]             r_dt2;
    logic signed [25:0]      r_tx, r_ty;

    // output register
    logic                    r_m_valid;
    logic [55:0]             r_m_data;

    // shared units
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_PW-1:0] prod;
    t_sdu_cmd          sdu_cmd;
    t_sdu_res          sdu_res;
    logic [NUM_W-1:0]  num;

    vpsc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    vpsc_sdu u_sdu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (sdu_cmd),
        .i_radicand (r_d2),
        .i_num      (num),
        .i_den      (r_d),
        .o_res      (sdu_res)
    );

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MXX:  begin mul_a = r_mx; mul_b = MUL_BW'(r_mx); end
            ST_MYY:  begin mul_a = r_my; mul_b = MUL_BW'(r_my); end
            ST_MRR:  begin mul_a = MUL_AW'(r_rad); mul_b = MUL_BW'(r_rad); end
            ST_MX:   begin mul_a = r_mx; mul_b = MUL_BW'(r_rad); end
            ST_MY:   begin mul_a = r_my; mul_b = MUL_BW'(r_rad); end
            ST_MDT:  begin mul_a = MUL_AW'(r_dt); mul_b = MUL_BW'(r_dt); end
            ST_MAX:  begin
                mul_a = r_ax_in[POS_W-1] ? MUL_AW'(-r_ax_in) : MUL_AW'(r_ax_in);
                mul_b = prod[31:0];
            end
            ST_MAY:  begin
                mul_a = r_ay_in[POS_W-1] ? MUL_AW'(-r_ay_in) : MUL_AW'(r_ay_in);
                mul_b = r_dt2;
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // rounded numerator for the projection divide
    assign num = prod[NUM_W-1:0] + NUM_W'(r_d >> 1);

    always_comb begin
        sdu_cmd.start = 1'b0;
        sdu_cmd.op    = SDU_DIV;
        if (r_state == ST_CMP && r_d2 > prod[SQ_W-1:0]) begin
            sdu_cmd.start = 1'b1;
            sdu_cmd.op    = SDU_SQRT;
        end else if (r_state == ST_DXS || r_state == ST_DYS) begin
            sdu_cmd.start = 1'b1;
        end
    end

    // rounded acceleration term of the current product, with sign
    logic [24:0]        acc_mag;
    logic signed [25:0] acc_term;
    logic               acc_neg;
    always_comb begin
        acc_mag  = 25'((57'(prod) + 57'(64'h8000_0000)) >> 32);
        acc_neg  = (r_state == ST_MAY) ? r_ax_in[POS_W-1] : r_ay_in[POS_W-1];
        acc_term = acc_neg ? -$signed({1'b0, acc_mag}) : $signed({1'b0, acc_mag});
    end

    // difference to center and projected positions
    logic signed [POS_W:0]   dx, dy;
    logic signed [27:0]      px, py, nx, ny;
    always_comb begin
        dx = $signed({r_cur_x[POS_W-1], r_cur_x}) - $signed({r_cx[POS_W-1], r_cx});
        dy = $signed({r_cur_y[POS_W-1], r_cur_y}) - $signed({r_cy[POS_W-1], r_cy});
        px = r_sx ? 28'(r_cx) - 28'($signed({1'b0, r_ox}))
                  : 28'(r_cx) + 28'($signed({1'b0, r_ox}));
        py = r_sy ? 28'(r_cy) - 28'($signed({1'b0, sdu_res.value[QUO_W-1:0]}))
                  : 28'(r_cy) + 28'($signed({1'b0, sdu_res.value[QUO_W-1:0]}));
        nx = 28'(r_cur_x) + 28'(r_cur_x) - 28'(r_prev_x) + 28'(r_tx);
        ny = 28'(r_cur_y) + 28'(r_cur_y) - 28'(r_prev_y) + 28'(r_ty);
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_cx      <= 24'sd179200;
            r_cy      <= 24'sd115200;
            r_rad     <= 23'd44800;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_clamp   <= 1'b0;
        end else begin
            // a commit in ST_OUT reloads the output register instead
            if (m_axis_tready && r_state != ST_OUT) r_m_valid <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_CENTER_X: r_cx  <= i_cfg_data;
                    REG_CENTER_Y: r_cy  <= i_cfg_data;
                    REG_LIMIT_R:  r_rad <= i_cfg_data[RAD_W-1:0];
                    default:      ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_load  <= s_axis_tuser;
                    r_ax_in <= s_axis_tdata[23:0];
                    r_ay_in <= s_axis_tdata[47:24];
                    r_dt    <= s_axis_tdata[63:48];
                    r_clamp <= 1'b0;
                    r_state <= s_axis_tuser ? ST_OUT : ST_DIFF;
                end
                ST_DIFF: begin
                    r_sx    <= dx[POS_W];
                    r_sy    <= dy[POS_W];
                    r_mx    <= dx[POS_W] ? POS_W'(-dx) : POS_W'(dx);
                    r_my    <= dy[POS_W] ? POS_W'(-dy) : POS_W'(dy);
                    r_state <= ST_MXX;
                end
                ST_MXX: r_state <= ST_MYY;
                ST_MYY: begin
                    r_d2    <= prod[SQ_W-1:0];
                    r_state <= ST_MRR;
                end
                ST_MRR: begin
                    r_d2    <= r_d2 + prod[SQ_W-1:0];
                    r_state <= ST_CMP;
                end
                ST_CMP: r_state <= sdu_cmd.start ? ST_SQRT : ST_MDT;
                ST_SQRT: if (sdu_res.done) begin
                    r_d     <= sdu_res.value;
                    r_state <= ST_MX;
                end
                ST_MX:  r_state <= ST_DXS;
                ST_DXS: r_state <= ST_DXW;
                ST_DXW: if (sdu_res.done) begin
                    r_ox    <= sdu_res.value[QUO_W-1:0];
                    r_state <= ST_MY;
                end
                ST_MY:  r_state <= ST_DYS;
                ST_DYS: r_state <= ST_DYW;
                ST_DYW: if (sdu_res.done) r_state <= ST_PROJ;
                ST_PROJ: begin
                    r_cur_x <= sat_pos(px);
                    r_cur_y <= sat_pos(py);
                    r_clamp <= 1'b1;
                    r_state <= ST_MDT;
                end
                ST_MDT: r_state <= ST_MAX;
                ST_MAX: begin
                    r_dt2   <= prod[31:0];
                    r_state <= ST_MAY;
                end
                ST_MAY: begin
                    r_tx    <= acc_term;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_ty    <= acc_term;
                    r_state <= ST_OUT;
                end
                ST_OUT: if (!r_m_valid || m_axis_tready) begin
                    r_m_valid <= 1'b1;
                    if (r_load) begin
                        r_cur_x  <= r_ax_in;
                        r_cur_y  <= r_ay_in;
                        r_prev_x <= r_ax_in;
                        r_prev_y <= r_ay_in;
                        r_m_data <= {7'd0, 1'b0, r_ay_in, r_ax_in};
                    end else begin
                        r_prev_x <= r_cur_x;
                        r_prev_y <= r_cur_y;
                        r_cur_x  <= sat_pos(nx);
                        r_cur_y  <= sat_pos(ny);
                        r_m_data <= {7'd0, r_clamp, sat_pos(ny), sat_pos(nx)};
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
